>>> hdl/dpalu_pkg.sv
// ----------------------------------------------------------------------------
// dpalu_pkg
// Types and constants shared by the data-processing ALU modules.
// ----------------------------------------------------------------------------
package dpalu_pkg;

	localparam int unsigned XLEN = 32;
	localparam int unsigned AMT_W = 8;
	localparam int unsigned REG_IDX_W = 4;
	localparam logic [REG_IDX_W-1:0] PC_INDEX = 4'hF;
	localparam logic [XLEN-1:0] PC_OFFSET = 32'd4;
	localparam logic [AMT_W-1:0] AMT_WORD = 8'd32;

	// stream packing
	localparam int unsigned S_TDATA_W = 112;
	localparam int unsigned S_TUSER_W = 2;
	localparam int unsigned M_TDATA_W = 48;

	typedef enum logic [1:0] {
		FORM_IMM       = 2'd0,
		FORM_IMM_SHIFT = 2'd1,
		FORM_REG_SHIFT = 2'd2
	} form_t;

	typedef enum logic [1:0] {
		SH_LSL = 2'd0,
		SH_LSR = 2'd1,
		SH_ASR = 2'd2,
		SH_ROR = 2'd3
	} shift_t;

	typedef enum logic [3:0] {
		OP_AND = 4'h0,
		OP_EOR = 4'h1,
		OP_SUB = 4'h2,
		OP_RSB = 4'h3,
		OP_ADD = 4'h4,
		OP_ADC = 4'h5,
		OP_SBC = 4'h6,
		OP_RSC = 4'h7,
		OP_TST = 4'h8,
		OP_TEQ = 4'h9,
		OP_CMP = 4'hA,
		OP_CMN = 4'hB,
		OP_ORR = 4'hC,
		OP_MOV = 4'hD,
		OP_BIC = 4'hE,
		OP_MVN = 4'hF
	} opcode_t;

	typedef struct packed {
		logic [XLEN-1:0] value;
		logic            carry;
	} operand_t;

	typedef struct packed {
		logic                 restore_psr;
		logic                 pc_written;
		logic                 flag_v;
		logic                 flag_c;
		logic                 flag_z;
		logic                 flag_n;
		logic                 flags_write;
		logic [REG_IDX_W-1:0] dest_index;
		logic                 write_result;
		logic [XLEN-1:0]      result;
	} alu_result_t;

endpackage

>>> hdl/arm_data_processing_alu_unit.sv
// ----------------------------------------------------------------------------
// arm_data_processing_alu_unit
// Execute-stage ALU for ARM data-processing instructions with barrel shifter.
// ----------------------------------------------------------------------------
// Takes one instruction transaction per clock and returns one result
// transaction per instruction, in order. The instruction is captured in an
// input register, the shifter and a single 32-bit adder evaluate in the
// following cycle, and the outcome lands in the result register, which drives
// the output. Throughput is one transaction per cycle while the output side
// keeps taking results; a stall on the output holds the result register, and
// the input ready drops in the same cycle once the input register also holds
// an instruction.
module arm_data_processing_alu_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	// instr_word, first_value, second_value, shift_value, carry_in, overflow_in
	input  logic [dpalu_pkg::S_TDATA_W-1:0]   s_axis_tdata,
	// command
	input  logic [dpalu_pkg::S_TUSER_W-1:0]   s_axis_tuser,
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	// result, write_result, dest_index, flags_write, flag_n, flag_z, flag_c,
	// flag_v, pc_written, restore_psr
	output logic [dpalu_pkg::M_TDATA_W-1:0]   m_axis_tdata
);
	import dpalu_pkg::*;

	logic                 valid_s1;
	logic                 valid_s2;
	logic                 adv_s1;
	logic [1:0]           command_s1;
	logic [XLEN-1:0]      instr_s1;
	logic [XLEN-1:0]      first_s1;
	logic [XLEN-1:0]      second_s1;
	logic [AMT_W-1:0]     shamt_s1;
	logic                 carry_s1;
	logic                 ovf_s1;
	operand_t             operand;
	alu_result_t          res;
	alu_result_t          res_s2;

	assign adv_s1        = !valid_s2 || m_axis_tready;
	assign s_axis_tready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (s_axis_tready) begin
				valid_s1 <= s_axis_tvalid;
			end
			if (adv_s1) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			command_s1 <= s_axis_tuser[1:0];
			instr_s1   <= s_axis_tdata[31:0];
			first_s1   <= s_axis_tdata[63:32];
			second_s1  <= s_axis_tdata[95:64];
			shamt_s1   <= s_axis_tdata[103:96];
			carry_s1   <= s_axis_tdata[104];
			ovf_s1     <= s_axis_tdata[105];
		end
		if (valid_s1 && adv_s1) begin
			res_s2 <= res;
		end
	end

	dpalu_shifter u_shifter (
		.command      (command_s1),
		.instr_word   (instr_s1),
		.second_value (second_s1),
		.shift_value  (shamt_s1),
		.carry_in     (carry_s1),
		.operand      (operand)
	);

	dpalu_alu u_alu (
		.command     (command_s1),
		.instr_word  (instr_s1),
		.first_value (first_s1),
		.operand     (operand),
		.carry_in    (carry_s1),
		.overflow_in (ovf_s1),
		.res         (res)
	);

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = {{(M_TDATA_W - $bits(alu_result_t)){1'b0}}, res_s2};

endmodule

>>> hdl/dpalu_shifter.sv
// ----------------------------------------------------------------------------
// dpalu_shifter
// Second operand generation: rotated immediate or barrel-shifted register.
// ----------------------------------------------------------------------------
module dpalu_shifter (
	input  logic [1:0]                  command,
	input  logic [dpalu_pkg::XLEN-1:0]  instr_word,
	input  logic [dpalu_pkg::XLEN-1:0]  second_value,
	input  logic [dpalu_pkg::AMT_W-1:0] shift_value,
	input  logic                        carry_in,
	output dpalu_pkg::operand_t         operand
);
	import dpalu_pkg::*;

	always_comb begin
		logic [XLEN-1:0]   rv;
		logic [XLEN-1:0]   imm8;
		logic [2*XLEN-1:0] dbl;
		logic [2*XLEN-1:0] lsl_ext;
		logic [2*XLEN-1:0] lsr_ext;
		logic signed [2*XLEN-1:0] asr_ext;
		logic [AMT_W-1:0]  amt;
		logic              bypass;
		logic              rrx;
		logic              big;
		shift_t            stype;

		stype   = shift_t'(instr_word[6:5]);
		rv      = second_value;
		amt     = shift_value;
		bypass  = 1'b0;
		rrx     = 1'b0;
		imm8    = {24'd0, instr_word[7:0]};
		dbl     = '0;
		lsl_ext = '0;
		lsr_ext = '0;
		asr_ext = '0;
		big     = 1'b0;
		operand = '{value: rv, carry: carry_in};

		if (form_t'(command) == FORM_IMM) begin
			dbl = {imm8, imm8} >> {instr_word[11:8], 1'b0};
			operand.value = dbl[XLEN-1:0];
			if (instr_word[11:8] != 4'd0) begin
				operand.carry = dbl[XLEN-1];
			end
		end else begin
			if (form_t'(command) == FORM_IMM_SHIFT) begin
				amt = {3'd0, instr_word[11:7]};
				// a zero immediate means no shift for lsl, rrx for ror, 32 otherwise
				if (instr_word[11:7] == 5'd0) begin
					unique case (stype)
						SH_LSL: bypass = 1'b1;
						SH_ROR: rrx = 1'b1;
						default: amt = AMT_WORD;
					endcase
				end
			end else begin
				// register-shifted form reads the pc ahead
				if (instr_word[3:0] == PC_INDEX) begin
					rv = second_value + PC_OFFSET;
				end
				bypass = (shift_value == '0);
			end

			big     = (amt[AMT_W-1:5] != '0);
			dbl     = {rv, rv} >> amt[4:0];
			lsl_ext = {32'd0, rv} << amt[4:0];
			lsr_ext = {rv, 32'd0} >> amt[4:0];
			asr_ext = $signed({rv, 32'd0}) >>> amt[4:0];

			priority if (bypass) begin
				operand = '{value: rv, carry: carry_in};
			end else if (rrx) begin
				operand = '{value: {carry_in, rv[XLEN-1:1]}, carry: rv[0]};
			end else begin
				unique case (stype)
					SH_LSL: begin
						if (!big) begin
							operand = '{value: lsl_ext[XLEN-1:0], carry: lsl_ext[XLEN]};
						end else begin
							operand = '{value: '0, carry: (amt == AMT_WORD) & rv[0]};
						end
					end
					SH_LSR: begin
						if (!big) begin
							operand = '{value: lsr_ext[2*XLEN-1:XLEN], carry: lsr_ext[XLEN-1]};
						end else begin
							operand = '{value: '0, carry: (amt == AMT_WORD) & rv[XLEN-1]};
						end
					end
					SH_ASR: begin
						if (!big) begin
							operand = '{value: asr_ext[2*XLEN-1:XLEN], carry: asr_ext[XLEN-1]};
						end else begin
							operand = '{value: {XLEN{rv[XLEN-1]}}, carry: rv[XLEN-1]};
						end
					end
					SH_ROR: begin
						operand = '{value: dbl[XLEN-1:0], carry: dbl[XLEN-1]};
					end
					default: operand = '{value: rv, carry: carry_in};
				endcase
			end
		end
	end

endmodule

>>> hdl/dpalu_alu.sv
// ----------------------------------------------------------------------------
// dpalu_alu
// Opcode execution, flag generation and destination control.
// ----------------------------------------------------------------------------
module dpalu_alu (
	input  logic [1:0]                 command,
	input  logic [dpalu_pkg::XLEN-1:0] instr_word,
	input  logic [dpalu_pkg::XLEN-1:0] first_value,
	input  dpalu_pkg::operand_t        operand,
	input  logic                       carry_in,
	input  logic                       overflow_in,
	output dpalu_pkg::alu_result_t     res
);
	import dpalu_pkg::*;

	always_comb begin
		logic [XLEN-1:0] a;
		logic [XLEN-1:0] b;
		logic [XLEN-1:0] x;
		logic [XLEN-1:0] y;
		logic            cy;
		logic [XLEN:0]   sum;
		logic [XLEN-1:0] val;
		logic            c;
		logic            v;
		logic            arith;
		logic            wr;
		logic            fw;
		logic            sbit;
		opcode_t         op;

		op   = opcode_t'(instr_word[24:21]);
		sbit = instr_word[20];
		a    = first_value;
		if (form_t'(command) != FORM_IMM && form_t'(command) != FORM_IMM_SHIFT &&
		    instr_word[19:16] == PC_INDEX) begin
			a = first_value + PC_OFFSET;
		end
		b = operand.value;

		// operand selection for the single adder
		x     = a;
		y     = b;
		cy    = 1'b0;
		arith = 1'b1;
		unique case (op)
			OP_SUB, OP_CMP: begin y = ~b; cy = 1'b1; end
			OP_RSB:         begin x = b; y = ~a; cy = 1'b1; end
			OP_ADD, OP_CMN: begin cy = 1'b0; end
			OP_ADC:         begin cy = carry_in; end
			OP_SBC:         begin y = ~b; cy = carry_in; end
			OP_RSC:         begin x = b; y = ~a; cy = carry_in; end
			default:        arith = 1'b0;
		endcase

		sum = {1'b0, x} + {1'b0, y} + {{XLEN{1'b0}}, cy};

		unique case (op)
			OP_AND, OP_TST: val = a & b;
			OP_EOR, OP_TEQ: val = a ^ b;
			OP_ORR:         val = a | b;
			OP_MOV:         val = b;
			OP_BIC:         val = a & ~b;
			OP_MVN:         val = ~b;
			default:        val = sum[XLEN-1:0];
		endcase

		c = arith ? sum[XLEN] : operand.carry;
		v = arith ? (~(x[XLEN-1] ^ y[XLEN-1]) & (x[XLEN-1] ^ sum[XLEN-1])) : overflow_in;

		wr = !(op == OP_TST || op == OP_TEQ || op == OP_CMP || op == OP_CMN);
		fw = sbit | ~wr;

		res.result       = wr ? val : '0;
		res.write_result = wr;
		res.dest_index   = instr_word[15:12];
		res.flags_write  = fw;
		res.flag_n       = fw & val[XLEN-1];
		res.flag_z       = fw & (val == '0);
		res.flag_c       = fw ? c : carry_in;
		res.flag_v       = fw ? v : overflow_in;
		res.pc_written   = (instr_word[15:12] == PC_INDEX) & wr;
		res.restore_psr  = (instr_word[15:12] == PC_INDEX) & sbit;
	end

endmodule
